// File: src/frs_pkg.sv
package frs_pkg;

	localparam int FIB_W      = 32;
	localparam int VAL_W      = 48;
	localparam int LOW_W      = 32;
	localparam int ACC_W      = 20;
	localparam int STEP_W     = ACC_W + 1;
	localparam int QC_W       = 6;
	localparam int IDX_W      = FIB_W + 1;
	localparam int DIFF_W     = LOW_W + 1;
	localparam int DIV_W      = 32;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int PROD_W     = IDX_W + STEP_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int ANS_W      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCURACY   = 2'd2;

	localparam logic [ANS_W-1:0] ANS_LESS    = 2'd0;
	localparam logic [ANS_W-1:0] ANS_GREATER = 2'd1;

	localparam logic FUNC_START  = 1'b0;
	localparam logic FUNC_ANSWER = 1'b1;

	localparam logic [QC_W-1:0] QC_MAX = '1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ASK,
		PH_EDGE,
		PH_FOUND
	} phase_t;

	typedef enum logic [1:0] {
		SEL_FIB,
		SEL_EDGE,
		SEL_ZERO
	} sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_CNT,
		S_FIB,
		S_MUL,
		S_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic start;
		logic answer;
		logic div_step;
		logic div_finish;
		logic fib_step;
		logic fib_finish;
		logic mul;
		logic emit;
	} frs_cmd_t;

	typedef struct packed {
		logic fib_more;
	} frs_sts_t;

endpackage

// File: src/frs_if.sv
interface frs_query_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [frs_pkg::ANS_W-1:0]   answer;

	modport source(output valid, func, answer, input ready);
	modport sink(input valid, func, answer, output ready);
endinterface

interface frs_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [frs_pkg::VAL_W-1:0]   probe_value;
	logic                               probe_valid;
	logic                               done_res;
	logic                               found;
	logic [frs_pkg::QC_W-1:0]           query_count;

	modport source(output valid, probe_value, probe_valid, done_res, found, query_count,
		input ready);
	modport sink(input valid, probe_value, probe_valid, done_res, found, query_count,
		output ready);
endinterface

// File: src/frs_ctrl.sv
module frs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output frs_pkg::frs_cmd_t cmd,
	input  frs_pkg::frs_sts_t sts
);

	frs_pkg::ctrl_state_t              state_q, state_d;
	logic [frs_pkg::DIV_CNT_W-1:0]     div_cnt_q;
	logic                              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			frs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == frs_pkg::FUNC_START) begin
						cmd.start = 1'b1;
						state_d   = frs_pkg::S_DIV;
					end else begin
						cmd.answer = 1'b1;
						state_d    = frs_pkg::S_MUL;
					end
				end
			end
			frs_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == frs_pkg::DIV_CNT_W'(frs_pkg::DIV_W - 1)) begin
					state_d = frs_pkg::S_CNT;
				end
			end
			frs_pkg::S_CNT: begin
				cmd.div_finish = 1'b1;
				state_d        = frs_pkg::S_FIB;
			end
			frs_pkg::S_FIB: begin
				if (sts.fib_more) begin
					cmd.fib_step = 1'b1;
				end else begin
					cmd.fib_finish = 1'b1;
					state_d        = frs_pkg::S_MUL;
				end
			end
			frs_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = frs_pkg::S_EMIT;
			end
			frs_pkg::S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = frs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = frs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + frs_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_answer_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.answer |=> cmd.mul)
		else $error("answer transaction did not go straight to probe multiply");

	a_div_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (cmd.div_step && div_cnt_q == '0))
		else $error("division did not start from step zero");

	a_div_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_finish |-> $past(div_cnt_q) == frs_pkg::DIV_CNT_W'(frs_pkg::DIV_W - 1))
		else $error("cell count taken before the last quotient bit");
`endif

endmodule

// File: src/frs_dp.sv
module frs_dp #(
	parameter int MAX_CELLS = 16777216
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [frs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [frs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [frs_pkg::ANS_W-1:0]           answer,
	input  frs_pkg::frs_cmd_t                   cmd,
	output frs_pkg::frs_sts_t                   sts,
	output logic signed [frs_pkg::VAL_W-1:0]    probe_value,
	output logic                                probe_valid,
	output logic                                done_res,
	output logic                                found,
	output logic [frs_pkg::QC_W-1:0]            query_count
);

	localparam int CNT_W = $clog2(MAX_CELLS + 1);
	localparam logic [frs_pkg::DIV_W-1:0] MAX_Q = frs_pkg::DIV_W'(MAX_CELLS);
	localparam logic [CNT_W-1:0]          MAX_N = CNT_W'(MAX_CELLS);

	logic [frs_pkg::LOW_W-1:0]           range_low_q, range_high_q;
	logic [frs_pkg::ACC_W-1:0]           accuracy_q;

	logic [frs_pkg::FIB_W-1:0]           fib_cur_q, fib_prev_q, fib_sp_q;
	logic [CNT_W-1:0]                    count_q;
	logic [frs_pkg::STEP_W-1:0]          step_q;
	logic                                went_left_q;
	logic [frs_pkg::QC_W-1:0]            probe_total_q;
	frs_pkg::phase_t                     phase_q;

	logic signed [frs_pkg::DIFF_W-1:0]   diff_q;
	logic                                acc_zero_q;
	logic [frs_pkg::DIV_W-1:0]           quot_q;
	logic [frs_pkg::STEP_W-1:0]          rem_q;
	logic [frs_pkg::FIB_W-1:0]           fa_q, fb_q, fc_q;
	frs_pkg::sel_t                       sel_q;
	logic                                res_valid_q, res_done_q, res_found_q;
	logic [frs_pkg::VAL_W-1:0]           prod_q;

	logic signed [frs_pkg::VAL_W-1:0]    probe_value_q;
	logic                                probe_valid_q, done_res_q, found_q;
	logic [frs_pkg::QC_W-1:0]            query_count_q;

	logic signed [frs_pkg::DIFF_W-1:0]   diff_c;
	logic [frs_pkg::STEP_W:0]            rem_sh;
	logic                                rem_ge;
	logic [CNT_W-1:0]                    count_c;
	logic signed [frs_pkg::IDX_W-1:0]    idx_c;
	logic signed [frs_pkg::STEP_W:0]     step_s;
	logic signed [frs_pkg::PROD_W-1:0]   prod_full;
	logic [frs_pkg::QC_W-1:0]            total_bump;
	logic [frs_pkg::VAL_W-1:0]           low_ext, acc_ext;

	assign diff_c = $signed({range_high_q[frs_pkg::LOW_W-1], range_high_q})
		- $signed({range_low_q[frs_pkg::LOW_W-1], range_low_q});

	assign rem_sh = {rem_q, quot_q[frs_pkg::DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, step_q};

	always_comb begin
		if (acc_zero_q) begin
			if (diff_q < 0) begin
				count_c = '0;
			end else if (diff_q >= $signed({1'b0, MAX_Q})) begin
				count_c = MAX_N;
			end else begin
				count_c = CNT_W'(diff_q[frs_pkg::DIFF_W-2:0] + frs_pkg::DIV_W'(1));
			end
		end else begin
			if (diff_q <= 0) begin
				count_c = '0;
			end else if (quot_q >= MAX_Q) begin
				count_c = MAX_N;
			end else begin
				count_c = CNT_W'(quot_q + frs_pkg::DIV_W'(1));
			end
		end
	end

	assign sts.fib_more = fa_q < frs_pkg::FIB_W'(count_q);

	always_comb begin
		unique case (sel_q)
			frs_pkg::SEL_FIB: begin
				idx_c = $signed({fib_cur_q[frs_pkg::FIB_W-1], fib_cur_q})
					- frs_pkg::IDX_W'(1);
			end
			frs_pkg::SEL_EDGE: begin
				if (went_left_q) begin
					idx_c = '0;
				end else begin
					idx_c = $signed({1'b0, frs_pkg::FIB_W'(count_q)}) - frs_pkg::IDX_W'(1);
				end
			end
			default: begin
				idx_c = '0;
			end
		endcase
	end

	assign step_s    = $signed({1'b0, step_q});
	assign prod_full = idx_c * step_s;

	assign total_bump = (probe_total_q == frs_pkg::QC_MAX) ? probe_total_q
		: probe_total_q + frs_pkg::QC_W'(1);

	assign low_ext = {{(frs_pkg::VAL_W - frs_pkg::LOW_W){range_low_q[frs_pkg::LOW_W-1]}},
		range_low_q};
	assign acc_ext = {{(frs_pkg::VAL_W - frs_pkg::ACC_W){1'b0}}, accuracy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '0;
			accuracy_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == frs_pkg::CFG_RANGE_LOW) begin
				range_low_q <= cfg_data[frs_pkg::LOW_W-1:0];
			end else if (cfg_index == frs_pkg::CFG_RANGE_HIGH) begin
				range_high_q <= cfg_data[frs_pkg::LOW_W-1:0];
			end else if (cfg_index == frs_pkg::CFG_ACCURACY) begin
				accuracy_q <= cfg_data[frs_pkg::ACC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fib_cur_q     <= '0;
			fib_prev_q    <= '0;
			fib_sp_q      <= '0;
			count_q       <= '0;
			step_q        <= frs_pkg::STEP_W'(1);
			went_left_q   <= 1'b0;
			probe_total_q <= '0;
			phase_q       <= frs_pkg::PH_IDLE;
			sel_q         <= frs_pkg::SEL_ZERO;
			res_valid_q   <= 1'b0;
			res_done_q    <= 1'b0;
			res_found_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				step_q <= (accuracy_q == '0) ? frs_pkg::STEP_W'(1) : {accuracy_q, 1'b0};
			end
			if (cmd.div_finish) begin
				count_q <= count_c;
			end
			if (cmd.fib_finish) begin
				fib_cur_q     <= fb_q;
				fib_prev_q    <= fc_q;
				fib_sp_q      <= fb_q - fc_q;
				went_left_q   <= 1'b0;
				probe_total_q <= frs_pkg::QC_W'(1);
				phase_q       <= frs_pkg::PH_ASK;
				sel_q         <= frs_pkg::SEL_FIB;
				res_valid_q   <= 1'b1;
				res_done_q    <= 1'b0;
				res_found_q   <= 1'b0;
			end
			if (cmd.answer) begin
				unique case (phase_q)
					frs_pkg::PH_ASK: begin
						if (answer == frs_pkg::ANS_LESS) begin
							went_left_q   <= 1'b1;
							probe_total_q <= total_bump;
							res_valid_q   <= 1'b1;
							res_done_q    <= 1'b0;
							res_found_q   <= 1'b0;
							if (fib_sp_q == '0) begin
								phase_q <= frs_pkg::PH_EDGE;
								sel_q   <= frs_pkg::SEL_EDGE;
							end else begin
								fib_cur_q  <= fib_cur_q - fib_sp_q;
								fib_prev_q <= fib_sp_q;
								fib_sp_q   <= fib_prev_q - fib_sp_q;
								sel_q      <= frs_pkg::SEL_FIB;
							end
						end else if (answer == frs_pkg::ANS_GREATER) begin
							probe_total_q <= total_bump;
							res_valid_q   <= 1'b1;
							res_done_q    <= 1'b0;
							res_found_q   <= 1'b0;
							if (fib_prev_q == frs_pkg::FIB_W'(1)) begin
								phase_q <= frs_pkg::PH_EDGE;
								sel_q   <= frs_pkg::SEL_EDGE;
							end else begin
								fib_cur_q  <= fib_cur_q + fib_sp_q;
								fib_prev_q <= fib_prev_q - fib_sp_q;
								fib_sp_q   <= fib_sp_q - (fib_prev_q - fib_sp_q);
								sel_q      <= frs_pkg::SEL_FIB;
							end
						end else begin
							phase_q     <= frs_pkg::PH_FOUND;
							sel_q       <= frs_pkg::SEL_FIB;
							res_valid_q <= 1'b0;
							res_done_q  <= 1'b1;
							res_found_q <= 1'b1;
						end
					end
					frs_pkg::PH_EDGE: begin
						sel_q       <= frs_pkg::SEL_EDGE;
						res_valid_q <= 1'b0;
						res_done_q  <= 1'b1;
						if (answer != frs_pkg::ANS_LESS && answer != frs_pkg::ANS_GREATER) begin
							phase_q     <= frs_pkg::PH_FOUND;
							res_found_q <= 1'b1;
						end else begin
							phase_q     <= frs_pkg::PH_IDLE;
							res_found_q <= 1'b0;
						end
					end
					frs_pkg::PH_FOUND: begin
						sel_q       <= frs_pkg::SEL_ZERO;
						res_valid_q <= 1'b0;
						res_done_q  <= 1'b1;
						res_found_q <= 1'b1;
					end
					default: begin
						sel_q       <= frs_pkg::SEL_ZERO;
						res_valid_q <= 1'b0;
						res_done_q  <= (probe_total_q != '0);
						res_found_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			diff_q     <= diff_c;
			acc_zero_q <= (accuracy_q == '0);
			quot_q     <= diff_c[frs_pkg::DIV_W-1:0] - frs_pkg::DIV_W'(1);
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? frs_pkg::STEP_W'(rem_sh - {1'b0, step_q})
				: rem_sh[frs_pkg::STEP_W-1:0];
			quot_q <= {quot_q[frs_pkg::DIV_W-2:0], rem_ge};
		end
		if (cmd.div_finish) begin
			fa_q <= frs_pkg::FIB_W'(1);
			fb_q <= frs_pkg::FIB_W'(1);
			fc_q <= '0;
		end else if (cmd.fib_step) begin
			fa_q <= fa_q + fb_q;
			fb_q <= fa_q;
			fc_q <= fb_q;
		end
		if (cmd.mul) begin
			prod_q <= prod_full[frs_pkg::VAL_W-1:0];
		end
		if (cmd.emit) begin
			probe_value_q <= (sel_q == frs_pkg::SEL_ZERO) ? '0
				: $signed(low_ext + acc_ext + prod_q);
			probe_valid_q <= res_valid_q;
			done_res_q    <= res_done_q;
			found_q       <= res_found_q;
			query_count_q <= probe_total_q;
		end
	end

	assign probe_value = probe_value_q;
	assign probe_valid = probe_valid_q;
	assign done_res    = done_res_q;
	assign found       = found_q;
	assign query_count = query_count_q;

`ifndef SYNTH
	a_active_has_probes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != frs_pkg::PH_IDLE) |-> (probe_total_q != '0))
		else $error("search active with no probe counted");

	a_fib_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fib_step |-> (fa_q >= fb_q))
		else $error("Fibonacci walk lost its ordering");
`endif

endmodule

// File: src/fibonacci_range_search_core.sv
// Fibonacci range search driven by an external oracle.
// query channel: func 0 starts a search over [range_low, range_high] using the
//   configuration registers; func 1 delivers the oracle answer to the last probe.
// result channel: exactly one transaction per query transaction, carrying the
//   probe value, probe_valid, done/found status and the probe count.
// Configuration: cfg_we/cfg_index/cfg_data, written only while the block is idle.
//   (a rule for the user; the block itself does not enforce it).
// Sequencing: an answer goes straight to the probe multiply and emit; a start
//   first runs the bit-serial cell count divider over DIV_W quotient bits and
//   the Fibonacci walk up to the cell count, then the same multiply and emit.
// Throughput: one transaction in flight; query.ready is high only while idle.
// A finished result sits in the output register, so the next query is taken
//   while that result waits; its own result then waits for the receiver.
// Reset zeroes the config and control registers (cell step to one) and leaves
//   the search idle; answers before any start report all zero status.
module fibonacci_range_search_core #(
	parameter int MAX_CELLS = 16777216
) (
	input  logic                             clk,
	input  logic                             arst_n,
	frs_query_if.sink                        query,
	frs_result_if.source                     result,
	input  logic                             cfg_we,
	input  logic [frs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [frs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	frs_pkg::frs_cmd_t cmd;
	frs_pkg::frs_sts_t sts;

	frs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.in_func   (query.func),
		.in_ready  (query.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	frs_dp #(
		.MAX_CELLS (MAX_CELLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.answer      (query.answer),
		.cmd         (cmd),
		.sts         (sts),
		.probe_value (result.probe_value),
		.probe_valid (result.probe_valid),
		.done_res    (result.done_res),
		.found       (result.found),
		.query_count (result.query_count)
	);

endmodule

// File: verif/fibonacci_range_search_core_test.sv
module fibonacci_range_search_core_test;
	import frs_pkg::*;

	localparam int CELL_LIMIT = 16777216;
	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_ANSWERS = 70;
	localparam logic [ANS_W-1:0] ANS_HIT = 2'd2;
	localparam logic [ANS_W-1:0] ANS_HIT_ALT = 2'd3;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             pvalid;
		logic             done;
		logic             found;
		logic [QC_W-1:0]  count;
	} probe_rsp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	frs_query_if qch();
	frs_result_if rch();

	fibonacci_range_search_core #(
		.MAX_CELLS(CELL_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.query(qch),
		.result(rch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// search state as the block should hold it
	logic [31:0] reg_low = '0;
	logic [31:0] reg_high = '0;
	logic [19:0] reg_acc = '0;
	logic [31:0] fib_cur = '0;
	logic [31:0] fib_prev = '0;
	logic [31:0] fib_sp = '0;
	logic [24:0] cell_count = '0;
	logic [20:0] cell_step = 21'd1;
	logic went_left = 1'b0;
	logic [QC_W-1:0] probe_total = '0;
	phase_t srch_phase = PH_IDLE;

	probe_rsp_t probe_expq[$];
	logic [VAL_W-1:0] last_probe = '0;
	longint search_target;
	int items_sent = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit stall_en = 1'b1;

	function automatic logic [VAL_W-1:0] cell_value(input longint idx);
		longint lo, ac, st, v;
		lo = $signed(reg_low);
		ac = reg_acc;
		st = cell_step;
		v = lo + ac + idx * st;
		return v[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] fib_probe();
		longint fc;
		fc = $signed(fib_cur);
		return cell_value(fc - 1);
	endfunction

	function automatic logic [VAL_W-1:0] edge_probe();
		longint last;
		last = cell_count;
		return went_left ? cell_value(0) : cell_value(last - 1);
	endfunction

	function automatic void issue(input logic [VAL_W-1:0] value, input logic pv,
		input logic done, input logic fnd);
		probe_rsp_t r;
		r.value = value;
		r.pvalid = pv;
		r.done = done;
		r.found = fnd;
		r.count = probe_total;
		probe_expq.push_back(r);
		last_probe = value;
	endfunction

	task automatic predict_search(input logic fn, input logic [ANS_W-1:0] ans);
		longint lo, hi, diff, n, seg, la;
		logic [31:0] wa, wb, wc, t;
		bit edge_hit;
		logic fnd;
		edge_hit = 1'b0;
		if (fn == FUNC_START) begin
			lo = $signed(reg_low);
			hi = $signed(reg_high);
			diff = hi - lo;
			if (reg_acc != 0) begin
				seg = reg_acc;
				seg = seg * 2;
				n = (diff <= 0) ? 0 : (diff + seg - 1) / seg;
				cell_step = seg[20:0];
			end else begin
				n = diff + 1;
				cell_step = 21'd1;
			end
			if (n < 0)
				n = 0;
			if (n > CELL_LIMIT)
				n = CELL_LIMIT;
			cell_count = n[24:0];
			wc = 32'd0;
			wb = 32'd1;
			wa = 32'd1;
			la = wa;
			while (la < n) begin
				wc = wb;
				wb = wa;
				wa = wb + wc;
				la = wa;
			end
			fib_cur = wb;
			fib_prev = wc;
			fib_sp = wb - wc;
			went_left = 1'b0;
			probe_total = QC_W'(1);
			srch_phase = PH_ASK;
			issue(fib_probe(), 1'b1, 1'b0, 1'b0);
		end else if (srch_phase == PH_ASK) begin
			if (ans == ANS_LESS || ans == ANS_GREATER) begin
				if (ans == ANS_LESS) begin
					went_left = 1'b1;
					if (fib_sp == 0) begin
						edge_hit = 1'b1;
					end else begin
						t = fib_prev;
						fib_cur = fib_cur - fib_sp;
						fib_prev = fib_sp;
						fib_sp = t - fib_sp;
					end
				end else begin
					if (fib_prev == 1) begin
						edge_hit = 1'b1;
					end else begin
						fib_cur = fib_cur + fib_sp;
						fib_prev = fib_prev - fib_sp;
						fib_sp = fib_sp - fib_prev;
					end
				end
				if (probe_total != QC_MAX)
					probe_total = probe_total + 1'b1;
				if (edge_hit) begin
					srch_phase = PH_EDGE;
					issue(edge_probe(), 1'b1, 1'b0, 1'b0);
				end else begin
					issue(fib_probe(), 1'b1, 1'b0, 1'b0);
				end
			end else begin
				srch_phase = PH_FOUND;
				issue(fib_probe(), 1'b0, 1'b1, 1'b1);
			end
		end else if (srch_phase == PH_EDGE) begin
			fnd = (ans >= ANS_HIT);
			srch_phase = fnd ? PH_FOUND : PH_IDLE;
			issue(edge_probe(), 1'b0, 1'b1, fnd);
		end else if (srch_phase == PH_FOUND) begin
			issue('0, 1'b0, 1'b1, 1'b1);
		end else begin
			issue('0, 1'b0, probe_total != 0, 1'b0);
		end
	endtask

	function automatic logic [ANS_W-1:0] oracle_reply();
		longint pv, tol;
		pv = $signed(last_probe);
		tol = reg_acc;
		if (search_target < pv - tol)
			return ANS_LESS;
		if (search_target > pv + tol)
			return ANS_GREATER;
		return $urandom_range(0, 1) ? ANS_HIT : ANS_HIT_ALT;
	endfunction

	task automatic send_query(input logic fn, input logic [ANS_W-1:0] ans);
		if (stall_en && $urandom_range(0, 3) == 0) begin
			qch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		qch.valid <= 1'b1;
		qch.func <= fn;
		qch.answer <= ans;
		@(posedge clk);
		while (!qch.ready)
			@(posedge clk);
		if (fn == FUNC_START || srch_phase inside {PH_ASK, PH_EDGE})
			items_sent++;
		predict_search(fn, ans);
	endtask

	task automatic wait_probes_settled();
		qch.valid <= 1'b0;
		while (probe_expq.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_search_regs(input logic [31:0] lo, input logic [31:0] hi,
		input logic [19:0] acc);
		wait_probes_settled();
		cfg_we <= 1'b1;
		cfg_index <= CFG_RANGE_LOW;
		cfg_data <= lo;
		@(posedge clk);
		reg_low = lo;
		cfg_index <= CFG_RANGE_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		reg_high = hi;
		cfg_index <= CFG_ACCURACY;
		cfg_data <= {12'd0, acc};
		@(posedge clk);
		reg_acc = acc;
		cfg_we <= 1'b0;
	endtask

	task automatic random_search_regs();
		int lo, hi;
		int unsigned acc;
		case ($urandom_range(0, 5))
			0: begin
				lo = $urandom_range(0, 200000) - 100000;
				hi = lo + $urandom_range(0, 400) - 50;
				acc = 0;
			end
			1: begin
				lo = $urandom_range(0, 2000000) - 1000000;
				hi = lo + $urandom_range(0, 1 << 20);
				acc = $urandom_range(1, 1000);
			end
			2: begin
				lo = $urandom;
				hi = $urandom;
				acc = $urandom_range(0, 1000000);
			end
			3: begin
				lo = 32'h8000_0000;
				hi = 32'h7fff_ffff;
				case ($urandom_range(0, 2))
					0: acc = 0;
					1: acc = 1;
					default: acc = 1000000;
				endcase
			end
			4: begin
				lo = $urandom_range(0, 2000000) - 1000000;
				hi = lo + $urandom_range(0, 10000) - 3000;
				acc = 1000;
			end
			default: begin
				lo = $urandom;
				hi = lo + $urandom;
				acc = $urandom_range(0, 1000000);
			end
		endcase
		load_search_regs(lo, hi, acc[19:0]);
	endtask

	// one oracle session; sometimes abandoned midway, sometimes trailed by stray answers
	task automatic run_search();
		longint lo, hi, span;
		logic [ANS_W-1:0] ans;
		int k;
		lo = $signed(reg_low);
		hi = $signed(reg_high);
		span = hi - lo;
		case ($urandom_range(0, 7))
			0: search_target = lo - $urandom_range(1, 5000);
			1: search_target = hi + $urandom_range(1, 5000);
			default: search_target = (span <= 0) ? lo : lo + longint'($urandom) % (span + 1);
		endcase
		send_query(FUNC_START, ANS_W'($urandom_range(0, 3)));
		k = 0;
		while (srch_phase inside {PH_ASK, PH_EDGE} && k < MAX_ANSWERS) begin
			if ($urandom_range(0, 29) == 0)
				break;
			if ($urandom_range(0, 6) == 0)
				ans = ANS_W'($urandom_range(0, 3));
			else
				ans = oracle_reply();
			send_query(FUNC_ANSWER, ans);
			k++;
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2))
				send_query(FUNC_ANSWER, ANS_W'($urandom_range(0, 3)));
	endtask

	task automatic test_answers_before_start();
		send_query(FUNC_ANSWER, ANS_LESS);
		send_query(FUNC_ANSWER, ANS_GREATER);
		send_query(FUNC_ANSWER, ANS_HIT_ALT);
		// reset registers: single cell
		send_query(FUNC_START, ANS_LESS);
		send_query(FUNC_ANSWER, ANS_GREATER);
		send_query(FUNC_ANSWER, ANS_GREATER);
	endtask

	task automatic test_directed_searches();
		// full 32-bit span, unit step, saturated count
		load_search_regs(32'h8000_0000, 32'h7fff_ffff, 20'd0);
		send_query(FUNC_START, ANS_HIT_ALT);
		send_query(FUNC_ANSWER, ANS_LESS);
		send_query(FUNC_ANSWER, ANS_GREATER);
		send_query(FUNC_ANSWER, ANS_HIT);
		send_query(FUNC_ANSWER, ANS_LESS);
		// wide cells, edge probe answered not found
		load_search_regs(-32'sd1000, 32'd5000000, 20'd1000000);
		send_query(FUNC_START, ANS_LESS);
		for (int k = 0; k < 6 && srch_phase == PH_ASK; k++)
			send_query(FUNC_ANSWER, ANS_LESS);
		send_query(FUNC_ANSWER, ANS_LESS);
		send_query(FUNC_ANSWER, ANS_GREATER);
		// inverted range: empty count, degenerate triple
		load_search_regs(32'h7fff_ffff, 32'h8000_0000, 20'd1);
		send_query(FUNC_START, ANS_GREATER);
		for (int k = 0; k < 6 && srch_phase == PH_ASK; k++)
			send_query(FUNC_ANSWER, ANS_GREATER);
		send_query(FUNC_ANSWER, ANS_HIT_ALT);
		// restart in the middle of a search
		load_search_regs(32'd0, 32'd999, 20'd0);
		send_query(FUNC_START, ANS_LESS);
		send_query(FUNC_ANSWER, ANS_GREATER);
		send_query(FUNC_START, ANS_GREATER);
		send_query(FUNC_ANSWER, ANS_HIT);
	endtask

	task automatic test_random_searches();
		int first, sessions;
		first = items_sent;
		sessions = 0;
		while (items_sent - first < RANDOM_ITEMS) begin
			if (sessions % 6 == 0)
				random_search_regs();
			if ($urandom_range(0, 19) == 0)
				wait_probes_settled();
			run_search();
			sessions++;
		end
	endtask

	task automatic test_unstalled_searches();
		stall_en = 1'b0;
		repeat (3) begin
			random_search_regs();
			repeat (4) run_search();
		end
	endtask

	task automatic log_mismatch(input string why, input probe_rsp_t exp_r,
		input probe_rsp_t got_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: exp val=%h pv=%b done=%b found=%b qc=%0d got val=%h pv=%b done=%b found=%b qc=%0d",
				why, exp_r.value, exp_r.pvalid, exp_r.done, exp_r.found, exp_r.count,
				got_r.value, got_r.pvalid, got_r.done, got_r.found, got_r.count);
	endtask

	always @(posedge clk) begin : result_check
		probe_rsp_t got_r, exp_r;
		if (arst_n && rch.valid && rch.ready) begin
			got_r.value = rch.probe_value;
			got_r.pvalid = rch.probe_valid;
			got_r.done = rch.done_res;
			got_r.found = rch.found;
			got_r.count = rch.query_count;
			if (probe_expq.size() == 0) begin
				log_mismatch("unexpected transaction", '0, got_r);
			end else begin
				exp_r = probe_expq.pop_front();
				if (got_r.value !== exp_r.value || got_r.pvalid !== exp_r.pvalid ||
					got_r.done !== exp_r.done || got_r.found !== exp_r.found ||
					got_r.count !== exp_r.count)
					log_mismatch("result mismatch", exp_r, got_r);
			end
		end
	end

	always @(posedge clk) begin
		if ((arst_n && qch.valid && qch.ready) || (arst_n && rch.valid && rch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		rch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_en && $urandom_range(0, 5) == 0) begin
				rch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			rch.ready <= 1'b1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		qch.valid <= 1'b0;
		qch.func <= FUNC_START;
		qch.answer <= ANS_LESS;
		cfg_we <= 1'b0;
		cfg_index <= CFG_RANGE_LOW;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_answers_before_start();
		test_directed_searches();
		test_random_searches();
		test_unstalled_searches();
		qch.valid <= 1'b0;
		while (probe_expq.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && probe_expq.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
src/frs_pkg.sv
src/frs_if.sv
src/frs_ctrl.sv
src/frs_dp.sv
src/fibonacci_range_search_core.sv
verif/fibonacci_range_search_core_test.sv
